>>> hw/rtl/fbm_pkg.sv
// Package: constants and hash helpers for the fractal Worley noise block.
package fbm_pkg;

    localparam int COORD_FRAC_BITS = 8;
    localparam int MAX_OCTAVES     = 8;
    localparam int OCT_W           = $clog2(MAX_OCTAVES);
    localparam int CFG_W           = 4;
    localparam int COORD_W         = 16;
    localparam int SCALED_W        = COORD_FRAC_BITS + 16;
    localparam int ROOT_W          = 18;
    localparam int SQ_W            = 36;
    localparam int REM_W           = 22;
    localparam int ACC_W           = 20;
    localparam int SQRT_STEPS      = ROOT_W;
    localparam int STEP_W          = $clog2(SQRT_STEPS + 1);

    localparam logic [15:0]    HF_A = 16'd58819;
    localparam logic [15:0]    HF_B = 16'd19484;
    localparam logic [15:0]    HF_C = 16'd12262;
    localparam logic [15:0]    HF_D = 16'd12452;
    localparam logic [26:0]    HF_K = 27'd80908635;
    localparam logic [15:0]    OFS_Y_HASH = 16'd37;
    localparam logic [15:0]    OFS_Z_HASH = 16'd74;
    localparam logic [CFG_W-1:0] OCT_RESET = 4'd4;

    typedef struct packed {
        logic [15:0] d;
        logic [16:0] t;
    } mix_t;

    // frac(v * mul + add), all modulo 2^16
    function automatic logic [15:0] frac16(input logic [15:0] v, input logic [15:0] mul,
                                           input logic [15:0] add);
        logic [31:0] p;
        p = v * mul;
        return p[15:0] + add;
    endfunction

    function automatic logic [15:0] mul_hi(input logic [15:0] a, input logic [15:0] b);
        logic [31:0] p;
        p = a * b;
        return p[31:16];
    endfunction

    // products of the three components: d and t terms
    function automatic mix_t hash_mix(input logic [15:0] hx, input logic [15:0] hy,
                                      input logic [15:0] hz);
        mix_t        m;
        logic [16:0] s;
        logic [32:0] p;
        s   = {1'b0, hx} + {1'b0, hy};
        p   = s * hz;
        m.t = p[32:16];
        m.d = mul_hi(hx, hy) + mul_hi(hy, hz) + mul_hi(hz, hx) + HF_D;
        return m;
    endfunction

    // final hash: bits [31:16] of t*K plus d
    function automatic logic [15:0] hash_fin(input mix_t m);
        logic [43:0] p;
        p = m.t * HF_K;
        return p[31:16] + m.d;
    endfunction

endpackage

>>> hw/rtl/fbm_in_if.sv
// Interface: sample point channel.
interface fbm_in_if;
    import fbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;

    modport source (output valid, output coord_x, output coord_y, output coord_z,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                    output ready);
endinterface

>>> hw/rtl/fbm_out_if.sv
// Interface: noise result channel.
interface fbm_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

>>> hw/rtl/fbm_worley_noise_3d.sv
// Top level: fractal Worley noise, one neighbor cell per cycle through a hash pipeline.
// Octaves: n = octave_count clipped to 1..MAX_OCTAVES (count 0 runs one silent octave);
//   the sequencer issues one cell beat per cycle unless stalled, and takes a new sample
//   as the last cell beat of the previous one issues. Path from accept to result beat:
//   7 pipe stages, 18-step root unit, output register.
// A stalled result freezes the whole pipeline, nothing is dropped or repeated.
// Reset (rst_n, async low): pipeline and sequencer empty, octave_count = 4.
module fbm_worley_noise_3d
    import fbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    fbm_in_if.sink           sample,
    fbm_out_if.source        noise
);

    typedef struct packed {
        logic [OCT_W-1:0] k;
        logic [1:0]       dx;
        logic [1:0]       dy;
        logic [1:0]       dz;
        logic             first;
        logic             last_cell;
        logic             last_oct;
        logic             mute;
    } ctl_t;

    typedef logic [2:0][15:0] fr3_t;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] oct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_reg <= OCT_RESET;
        end
        else if (cfg_we)
        begin
            oct_reg <= cfg_wdata;
        end
    end

    // global advance: output slot free or being drained
    logic out_vld_reg;
    logic adv;
    assign adv = !out_vld_reg || noise.ready;

    // ---------------- sequencer ----------------
    // walks octaves and the 27 neighbor cells of the held sample
    logic               seq_busy_reg;
    logic [COORD_W-1:0] seq_x_reg, seq_y_reg, seq_z_reg;
    logic [OCT_W-1:0]   seq_nm1_reg;
    logic               seq_mute_reg;
    logic [OCT_W-1:0]   seq_k_reg;
    logic [1:0]         seq_dx_reg, seq_dy_reg, seq_dz_reg;
    logic               seq_last_cell, seq_last;
    logic               take;
    logic [OCT_W-1:0]   nm1_next;
    logic               mute_next;

    assign seq_last_cell = (seq_dx_reg == 2'd2) && (seq_dy_reg == 2'd2) && (seq_dz_reg == 2'd2);
    assign seq_last      = seq_last_cell && (seq_k_reg == seq_nm1_reg);
    assign sample.ready  = !seq_busy_reg || (seq_last && adv);
    assign take          = sample.valid && sample.ready;

    always_comb
    begin
        mute_next = 1'b0;
        if (oct_reg == '0)
        begin
            nm1_next  = '0;
            mute_next = 1'b1;
        end
        else if (oct_reg > CFG_W'(MAX_OCTAVES))
        begin
            nm1_next = OCT_W'(MAX_OCTAVES - 1);
        end
        else
        begin
            nm1_next = OCT_W'(oct_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_busy_reg <= 1'b0;
            seq_k_reg    <= '0;
            seq_dx_reg   <= '0;
            seq_dy_reg   <= '0;
            seq_dz_reg   <= '0;
            seq_nm1_reg  <= '0;
            seq_mute_reg <= 1'b0;
        end
        else if (take)
        begin
            seq_busy_reg <= 1'b1;
            seq_k_reg    <= '0;
            seq_dx_reg   <= '0;
            seq_dy_reg   <= '0;
            seq_dz_reg   <= '0;
            seq_nm1_reg  <= nm1_next;
            seq_mute_reg <= mute_next;
        end
        else if (seq_busy_reg && adv)
        begin
            if (seq_last)
            begin
                seq_busy_reg <= 1'b0;
            end
            if (seq_dz_reg != 2'd2)
            begin
                seq_dz_reg <= seq_dz_reg + 2'd1;
            end
            else
            begin
                seq_dz_reg <= '0;
                if (seq_dy_reg != 2'd2)
                begin
                    seq_dy_reg <= seq_dy_reg + 2'd1;
                end
                else
                begin
                    seq_dy_reg <= '0;
                    if (seq_dx_reg != 2'd2)
                    begin
                        seq_dx_reg <= seq_dx_reg + 2'd1;
                    end
                    else
                    begin
                        seq_dx_reg <= '0;
                        seq_k_reg  <= seq_k_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seq_x_reg <= sample.coord_x;
            seq_y_reg <= sample.coord_y;
            seq_z_reg <= sample.coord_z;
        end
    end

    // ---------------- stage 0: cell and fraction ----------------
    logic [SCALED_W-1:0] sc_x, sc_y, sc_z;
    logic [15:0]         c0_x, c0_y, c0_z;
    ctl_t                c0_ctl;

    assign sc_x = SCALED_W'(seq_x_reg) << seq_k_reg;
    assign sc_y = SCALED_W'(seq_y_reg) << seq_k_reg;
    assign sc_z = SCALED_W'(seq_z_reg) << seq_k_reg;
    // neighbor offset dx-1, wraps modulo 2^16 (hash only sees low 16 bits)
    assign c0_x = sc_x[COORD_FRAC_BITS +: 16] + 16'(seq_dx_reg) - 16'd1;
    assign c0_y = sc_y[COORD_FRAC_BITS +: 16] + 16'(seq_dy_reg) - 16'd1;
    assign c0_z = sc_z[COORD_FRAC_BITS +: 16] + 16'(seq_dz_reg) - 16'd1;

    always_comb
    begin
        c0_ctl.k         = seq_k_reg;
        c0_ctl.dx        = seq_dx_reg;
        c0_ctl.dy        = seq_dy_reg;
        c0_ctl.dz        = seq_dz_reg;
        c0_ctl.first     = (seq_dx_reg == 2'd0) && (seq_dy_reg == 2'd0) && (seq_dz_reg == 2'd0);
        c0_ctl.last_cell = seq_last_cell;
        c0_ctl.last_oct  = (seq_k_reg == seq_nm1_reg);
        c0_ctl.mute      = seq_mute_reg;
    end

    logic        v0_reg;
    logic [15:0] p0_x_reg, p0_y_reg, p0_z_reg;
    fr3_t        p0_fr_reg;
    ctl_t        p0_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_x_reg     <= c0_x;
            p0_y_reg     <= c0_y;
            p0_z_reg     <= c0_z;
            p0_fr_reg[0] <= 16'(sc_x[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
            p0_fr_reg[1] <= 16'(sc_y[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
            p0_fr_reg[2] <= 16'(sc_z[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS);
            p0_ctl_reg   <= c0_ctl;
        end
    end

    // ---------------- stage 1: component hashes ----------------
    // hx of cell and cell+37, hy of cell and cell+74, hz shared
    logic        v1_reg;
    logic [15:0] p1_hx0_reg, p1_hx1_reg, p1_hy0_reg, p1_hy1_reg, p1_hz_reg;
    fr3_t        p1_fr_reg;
    ctl_t        p1_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_hx0_reg <= frac16(p0_x_reg, HF_A, HF_B);
            p1_hx1_reg <= frac16(p0_x_reg + OFS_Y_HASH, HF_A, HF_B);
            p1_hy0_reg <= frac16(p0_y_reg, HF_B, HF_C);
            p1_hy1_reg <= frac16(p0_y_reg + OFS_Z_HASH, HF_B, HF_C);
            p1_hz_reg  <= frac16(p0_z_reg, HF_C, HF_A);
            p1_fr_reg  <= p0_fr_reg;
            p1_ctl_reg <= p0_ctl_reg;
        end
    end

    // ---------------- stage 2: cross products ----------------
    logic  v2_reg;
    mix_t  p2_mix_reg [3];
    fr3_t  p2_fr_reg;
    ctl_t  p2_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_mix_reg[0] <= hash_mix(p1_hx0_reg, p1_hy0_reg, p1_hz_reg);
            p2_mix_reg[1] <= hash_mix(p1_hx1_reg, p1_hy0_reg, p1_hz_reg);
            p2_mix_reg[2] <= hash_mix(p1_hx0_reg, p1_hy1_reg, p1_hz_reg);
            p2_fr_reg     <= p1_fr_reg;
            p2_ctl_reg    <= p1_ctl_reg;
        end
    end

    // ---------------- stage 3: feature point ----------------
    logic        v3_reg;
    logic [15:0] p3_pt_reg [3];
    fr3_t        p3_fr_reg;
    ctl_t        p3_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p3_pt_reg[i] <= hash_fin(p2_mix_reg[i]);
            end
            p3_fr_reg  <= p2_fr_reg;
            p3_ctl_reg <= p2_ctl_reg;
        end
    end

    // ---------------- stage 4: offsets ----------------
    logic signed [18:0] e4 [3];
    logic signed [18:0] base4 [3];
    logic [1:0]         dsel [3];

    assign dsel[0] = p3_ctl_reg.dx;
    assign dsel[1] = p3_ctl_reg.dy;
    assign dsel[2] = p3_ctl_reg.dz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (dsel[i])
                2'd0:    base4[i] = -19'sd65536;
                2'd2:    base4[i] = 19'sd65536;
                default: base4[i] = 19'sd0;
            endcase
            e4[i] = base4[i] + $signed({3'b000, p3_pt_reg[i]})
                    - $signed({3'b000, p3_fr_reg[i]});
        end
    end

    logic               v4_reg;
    logic signed [18:0] p4_e_reg [3];
    ctl_t               p4_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p4_e_reg[i] <= e4[i];
            end
            p4_ctl_reg <= p3_ctl_reg;
        end
    end

    // ---------------- stage 5: squares ----------------
    logic signed [37:0] m5 [3];
    logic               v5_reg;
    logic [33:0]        p5_sq_reg [3];
    ctl_t               p5_ctl_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            m5[i] = p4_e_reg[i] * p4_e_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p5_sq_reg[i] <= m5[i][33:0];
            end
            p5_ctl_reg <= p4_ctl_reg;
        end
    end

    // ---------------- stage 6: distance sum ----------------
    logic            v6_reg;
    logic [SQ_W-1:0] p6_sum_reg;
    ctl_t            p6_ctl_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_sum_reg <= SQ_W'(p5_sq_reg[0]) + SQ_W'(p5_sq_reg[1]) + SQ_W'(p5_sq_reg[2]);
            p6_ctl_reg <= p5_ctl_reg;
        end
    end

    // valid bits travel with the beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= seq_busy_reg;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ---------------- stage 7: running minimum ----------------
    logic [SQ_W-1:0] best_reg;
    logic [SQ_W-1:0] best_next;
    logic            rt_load;

    assign best_next = (p6_ctl_reg.first || (p6_sum_reg < best_reg)) ? p6_sum_reg : best_reg;
    assign rt_load   = adv && v6_reg && p6_ctl_reg.last_cell;

    always_ff @(posedge clk)
    begin
        if (adv && v6_reg)
        begin
            best_reg <= best_next;
        end
    end

    // ---------------- root unit: one result bit per cycle unless stalled ----------------
    logic              rt_busy_reg;
    logic [STEP_W-1:0] rt_cnt_reg;
    logic [SQ_W-1:0]   rt_rad_reg;
    logic [REM_W-1:0]  rt_rem_reg;
    logic [ROOT_W-1:0] rt_root_reg;
    ctl_t              rt_ctl_reg;
    logic [REM_W-1:0]  rem_sh, trial, rem_next;
    logic [ROOT_W-1:0] root_next;
    logic              rt_done;
    logic [ROOT_W-1:0] contrib;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_sum;
    logic [15:0]       out_data_reg;

    always_comb
    begin
        rem_sh = {rt_rem_reg[REM_W-3:0], rt_rad_reg[SQ_W-1 -: 2]};
        trial  = {2'b00, rt_root_reg, 2'b01};
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {rt_root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {rt_root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    assign rt_done = adv && rt_busy_reg && (rt_cnt_reg == STEP_W'(1));
    // octave k weight 2^-(k+2) on the Q.16 root gives Q0.16
    assign contrib = rt_ctl_reg.mute ? '0
                     : (root_next >> (4'(rt_ctl_reg.k) + 4'd2));
    assign acc_sum = acc_reg + ACC_W'(contrib);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_busy_reg <= 1'b0;
            rt_cnt_reg  <= '0;
            acc_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (rt_done && rt_ctl_reg.last_oct)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_vld_reg && noise.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (rt_load)
            begin
                rt_busy_reg <= 1'b1;
                rt_cnt_reg  <= STEP_W'(SQRT_STEPS);
            end
            else if (adv && rt_busy_reg)
            begin
                rt_cnt_reg <= rt_cnt_reg - 1'b1;
                if (rt_done)
                begin
                    rt_busy_reg <= 1'b0;
                end
            end
            if (rt_done)
            begin
                if (rt_ctl_reg.last_oct)
                begin
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rt_load)
        begin
            rt_rad_reg  <= best_next;
            rt_rem_reg  <= '0;
            rt_root_reg <= '0;
            rt_ctl_reg  <= p6_ctl_reg;
        end
        else if (adv && rt_busy_reg)
        begin
            rt_rad_reg  <= rt_rad_reg << 2;
            rt_rem_reg  <= rem_next;
            rt_root_reg <= root_next;
        end
        if (rt_done && rt_ctl_reg.last_oct)
        begin
            out_data_reg <= (|acc_sum[ACC_W-1:16]) ? 16'hFFFF : acc_sum[15:0];
        end
    end

    assign noise.valid       = out_vld_reg;
    assign noise.noise_value = out_data_reg;

endmodule

>>> bench/fbm_noise_scoreboard.sv
// Scoreboard class: predicts fractal Worley noise and checks result beats.
`timescale 1ns / 1ps

class fbm_noise_scoreboard;
    logic [3:0]  octaves;
    logic [15:0] pending_noise[$];
    int          mismatches;
    int          unexpected;

    function new();
        octaves     = 4'd4;
        mismatches  = 0;
        unexpected  = 0;
    endfunction

    function void set_octaves(logic [3:0] n);
        octaves = n;
    endfunction

    // cell coordinates are 32 bits wide, only the low 16 reach the hash
    function automatic logic [15:0] feature_hash(logic [31:0] cx, logic [31:0] cy,
                                                 logic [31:0] cz);
        logic [63:0] hx, hy, hz, d, t, u;
        hx = ({48'd0, cx[15:0]} * 64'd58819 + 64'd19484) & 64'hFFFF;
        hy = ({48'd0, cy[15:0]} * 64'd19484 + 64'd12262) & 64'hFFFF;
        hz = ({48'd0, cz[15:0]} * 64'd12262 + 64'd58819) & 64'hFFFF;
        d  = ((hx * hy) >> 16) + ((hy * hz) >> 16) + ((hz * hx) >> 16) + 64'd12452;
        t  = ((hx + hy) * hz) >> 16;
        u  = (t * 64'd80908635) >> 16;
        return u[15:0] + d[15:0];
    endfunction

    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [63:0] r, c;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] octave_distance(logic [15:0] p[3], int k);
        logic [31:0]    cell_pos[3];
        longint         fr[3];
        longint         ex, ey, ez;
        logic [63:0]    s, sq, best;
        logic [31:0]    cx, cy, cz;
        best = '1;
        for (int i = 0; i < 3; i++)
        begin
            s           = {48'd0, p[i]} << k;
            cell_pos[i] = s[39:8];
            fr[i]       = longint'(s[7:0]) << 8;
        end
        for (int dx = -1; dx <= 1; dx++)
            for (int dy = -1; dy <= 1; dy++)
                for (int dz = -1; dz <= 1; dz++)
                begin
                    cx = cell_pos[0] + dx;
                    cy = cell_pos[1] + dy;
                    cz = cell_pos[2] + dz;
                    ex = longint'(dx) * 65536 + feature_hash(cx, cy, cz) - fr[0];
                    ey = longint'(dy) * 65536 + feature_hash(cx + 37, cy, cz) - fr[1];
                    ez = longint'(dz) * 65536 + feature_hash(cx, cy + 74, cz) - fr[2];
                    sq = ex * ex + ey * ey + ez * ez;
                    if (sq < best)
                        best = sq;
                end
        return floor_root(best);
    endfunction

    function void note_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        logic [15:0] p[3];
        logic [63:0] acc;
        int          n;
        p[0] = x; p[1] = y; p[2] = z;
        n    = (octaves > 8) ? 8 : octaves;
        acc  = 0;
        for (int k = 0; k < n; k++)
            acc += octave_distance(p, k) >> (k + 2);
        pending_noise.push_back(acc > 64'hFFFF ? 16'hFFFF : acc[15:0]);
    endfunction

    function void check_noise(logic [15:0] got);
        logic [15:0] want;
        if (pending_noise.size() == 0)
        begin
            unexpected++;
            if (mismatches + unexpected <= 10)
                $display("noise beat %h with nothing pending", got);
            return;
        end
        want = pending_noise.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("noise_value mismatch: expected %h got %h", want, got);
        end
    endfunction
endclass

>>> bench/tb_fbm_worley_noise_3d.sv
// Testbench top: drives sample beats and octave settings, checks noise beats.
`timescale 1ns / 1ps

module tb_fbm_worley_noise_3d;
    import fbm_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               cycle_count;
    bit               quiet_mode;     // long stretch with no idling on either side

    fbm_in_if  sample ();
    fbm_out_if noise ();

    fbm_noise_scoreboard noise_board;

    fbm_worley_noise_3d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (sample.sink),
        .noise     (noise.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Timeout: bounds a run of about 2000 samples at up to 8 octaves each, plus stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("FAIL fbm_worley_noise_3d");
            $finish;
        end
    end

    // Monitor: sample both sides at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && sample.valid && sample.ready)
            noise_board.note_sample(sample.coord_x, sample.coord_y, sample.coord_z);
        if (rst_n && noise.valid && noise.ready)
            noise_board.check_noise(noise.noise_value);
    end

    // Result side backpressure, changed at the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            noise.ready <= 1'b0;
        else
            noise.ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 10);
    end

    // One sample beat; random sender gaps before it. Valid stays high after
    // the beat so back to back beats need no gap; drain_pipe drops it.
    task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        while (!quiet_mode && $urandom_range(99) < 10)
        begin
            sample.valid <= 1'b0;
            @(negedge clk);
        end
        sample.valid   <= 1'b1;
        sample.coord_x <= x;
        sample.coord_y <= y;
        sample.coord_z <= z;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Wait until every pending noise beat has arrived, then let the pipe drain.
    task automatic drain_pipe();
        sample.valid <= 1'b0;
        while (noise_board.pending_noise.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_octaves(logic [3:0] n);
        drain_pipe();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(negedge clk);
        cfg_we    <= 1'b0;
        noise_board.set_octaves(n);
    endtask

    task automatic send_random(int count);
        logic [15:0] c[3];
        for (int i = 0; i < count; i++)
        begin
            for (int j = 0; j < 3; j++)
                case ($urandom_range(3))
                    0:       c[j] = 16'($urandom_range(767));    // small, near cell 0
                    1:       c[j] = 16'(16'hFFFF - $urandom_range(255));
                    default: c[j] = 16'($urandom);
                endcase
            send_sample(c[0], c[1], c[2]);
        end
    endtask

    initial
    begin
        logic [3:0] octave_plan[10];
        noise_board     = new();
        cycle_count     = 0;
        quiet_mode      = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        sample.valid    = 1'b0;
        sample.coord_x  = '0;
        sample.coord_y  = '0;
        sample.coord_z  = '0;
        noise.ready     = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset octave count, field extremes, cells at zero.
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h00FF, 16'h0100, 16'h8000);
        send_sample(16'h5555, 16'hAAAA, 16'h0001);
        // zero octaves gives 0
        write_octaves(4'd0);
        send_sample(16'h1234, 16'h5678, 16'h9ABC);
        // one octave, then the clip above the max octave count
        write_octaves(4'd1);
        send_sample(16'h0000, 16'hFFFF, 16'h0080);
        send_sample(16'hFFFF, 16'h0000, 16'h7FFF);
        write_octaves(4'd15);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_octaves(4'd8);
        send_sample(16'h00C0, 16'h0040, 16'hFF80);
        send_sample(16'h7F7F, 16'h8080, 16'h0000);
        write_octaves(4'd9);
        send_sample(16'h0101, 16'hFEFE, 16'h0202);

        // Random phases, mostly small octave counts to keep the run short.
        octave_plan = '{4'd2, 4'd1, 4'd4, 4'd3, 4'd8, 4'd0, 4'd2, 4'd15, 4'd1, 4'd5};
        foreach (octave_plan[p])
        begin
            write_octaves(octave_plan[p]);
            quiet_mode = (p == 2);
            send_random(octave_plan[p] >= 8 ? 60 : 230);
            quiet_mode = 1'b0;
        end

        drain_pipe();
        if (noise_board.mismatches == 0 && noise_board.unexpected == 0)
            $display("PASS fbm_worley_noise_3d");
        else
            $display("FAIL fbm_worley_noise_3d");
        $finish;
    end
endmodule

>>> sim.f
hw/rtl/fbm_pkg.sv
hw/rtl/fbm_in_if.sv
hw/rtl/fbm_out_if.sv
hw/rtl/fbm_worley_noise_3d.sv
bench/fbm_noise_scoreboard.sv
bench/tb_fbm_worley_noise_3d.sv
